// ===== design/ddsr_pkg.sv =====
// Shared types, constants and helpers for the speed/radius framer.
package ddsr_pkg;

    localparam int QuotW   = 27;
    localparam int DivSteps = 3;
    localparam int DivBits = QuotW / DivSteps;
    localparam int FrameLen = 10;
    localparam int IdxW = 4;
    localparam int RecipShift = 35;

    localparam logic [25:0] Recip1000 = 26'd34359739;

    localparam logic [7:0] HeadB0 = 8'hAA;
    localparam logic [7:0] HeadB1 = 8'h55;
    localparam logic [7:0] HeadB2 = 8'h05;
    localparam logic [7:0] HeadB3 = 8'h01;
    localparam logic [7:0] HeadB4 = 8'h04;
    localparam logic [9:0] HwbReset = 10'd115;

    typedef struct packed {
        logic signed [15:0] translation_mm_s;
        logic signed [15:0] rotation_mrad_s;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] radius;
    } sr_t;

    typedef enum logic [1:0] {
        MODE_ROT,
        MODE_TRANS,
        MODE_BOTH
    } mode_t;

    function automatic logic [15:0] sat16(input logic signed [27:0] v);
        logic [15:0] r;
        if (v > 28'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -28'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/diff_drive_speed_radius_frame.sv =====
// Top level: velocity command in, 10-byte speed/radius frame out.
// A request is registered through the product, division and select stages, then loaded into the byte serializer.
// The byte serializer takes a new request only as the last byte of the current frame is accepted.
// The math pipeline takes a request every cycle and holds whole while its head waits.
// Synchronous active-low reset clears all valid bits; half wheelbase resets to 115.
module diff_drive_speed_radius_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ddsr_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ddsr_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  logic [9:0]           cfg_wdata
);
    import ddsr_pkg::*;

    logic [9:0] hwb_reg;
    logic       calc_valid;
    sr_t        calc_sr;
    logic       fr_ready;
    logic       adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwb_reg <= HwbReset;
        end else if (cfg_we) begin
            hwb_reg <= cfg_wdata;
        end
    end

    // advance the math pipe unless its head is held
    assign adv     = !calc_valid || fr_ready;
    assign s_ready = adv;

    ddsr_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .hwb       (hwb_reg),
        .out_valid (calc_valid),
        .out_sr    (calc_sr)
    );

    ddsr_frame u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (calc_valid),
        .in_ready (fr_ready),
        .in_sr    (calc_sr),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_data)
    );

endmodule

// ===== design/ddsr_calc.sv =====
// Pipelined speed and radius math: products, restoring division, select.
module ddsr_calc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  ddsr_pkg::in_item_t    in_item,
    input  logic [9:0]            hwb,
    output logic                  out_valid,
    output ddsr_pkg::sr_t         out_sr
);
    import ddsr_pkg::*;

    // stage valid bits: 0 products, 1..3 division, 4 select
    logic [4:0] v_reg;

    // stage 0 data
    mode_t              mode0_reg;
    logic signed [16:0] t0_reg;
    logic [25:0]        wh0_reg;
    logic               whneg0_reg;
    logic [QuotW-1:0]   num0_reg;
    logic [15:0]        den0_reg;
    logic               qneg0_reg;

    // division pipeline
    mode_t              mode_d_reg [DivSteps];
    logic signed [16:0] t_d_reg    [DivSteps];
    logic signed [16:0] term_d_reg [DivSteps];
    logic [QuotW-1:0]   num_d_reg  [DivSteps];
    logic [16:0]        rem_d_reg  [DivSteps];
    logic [15:0]        den_d_reg  [DivSteps];
    logic               qneg_d_reg [DivSteps];

    sr_t sr_reg;

    logic signed [25:0] prod_t;
    logic [25:0]        abs_num;
    logic [15:0]        abs_den;
    logic [25:0]        wh_mag;

    always_comb begin
        prod_t    = 26'(in_item.translation_mm_s) * 26'sd1000;
        abs_num   = prod_t[25] ? 26'(-prod_t) : prod_t;
        abs_den   = in_item.rotation_mrad_s[15] ? 16'(-in_item.rotation_mrad_s)
                                               : in_item.rotation_mrad_s;
        wh_mag    = 26'(abs_den) * 26'(hwb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (in_item.translation_mm_s == 16'sd0) begin
                mode0_reg <= MODE_ROT;
            end else if (in_item.rotation_mrad_s == 16'sd0) begin
                mode0_reg <= MODE_TRANS;
            end else begin
                mode0_reg <= MODE_BOTH;
            end
            t0_reg     <= 17'(in_item.translation_mm_s);
            wh0_reg    <= wh_mag;
            whneg0_reg <= in_item.rotation_mrad_s[15];
            num0_reg   <= QuotW'(abs_num);
            den0_reg   <= abs_den;
            qneg0_reg  <= in_item.translation_mm_s[15] ^ in_item.rotation_mrad_s[15];
        end
    end

    for (genvar s = 0; s < DivSteps; s++) begin : g_div
        logic [QuotW-1:0]   num_in;
        logic [16:0]        rem_in;
        logic [15:0]        den_in;
        mode_t              mode_in;
        logic signed [16:0] t_in;
        logic signed [16:0] term_in;
        logic               qneg_in;
        logic [QuotW-1:0]   num_out;
        logic [16:0]        rem_out;
        logic [17:0]        trial;
        if (s == 0) begin : g_first
            logic [51:0] recip_p;
            logic [16:0] tmag;
            assign recip_p = 52'(wh0_reg) * 52'(Recip1000);
            assign tmag    = {1'b0, recip_p[RecipShift+15:RecipShift]};
            assign term_in = whneg0_reg ? -tmag : tmag;
            assign num_in  = num0_reg;
            assign rem_in  = '0;
            assign den_in  = den0_reg;
            assign mode_in = mode0_reg;
            assign t_in    = t0_reg;
            assign qneg_in = qneg0_reg;
        end else begin : g_rest
            assign num_in  = num_d_reg[s-1];
            assign rem_in  = rem_d_reg[s-1];
            assign den_in  = den_d_reg[s-1];
            assign mode_in = mode_d_reg[s-1];
            assign t_in    = t_d_reg[s-1];
            assign term_in = term_d_reg[s-1];
            assign qneg_in = qneg_d_reg[s-1];
        end
        always_comb begin
            num_out = num_in;
            rem_out = rem_in;
            for (int b = 0; b < DivBits; b++) begin
                trial   = {rem_out, num_out[QuotW-1]};
                num_out = {num_out[QuotW-2:0], 1'b0};
                if (trial >= {2'b00, den_in}) begin
                    rem_out    = 17'(trial - {2'b00, den_in});
                    num_out[0] = 1'b1;
                end else begin
                    rem_out = trial[16:0];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                num_d_reg[s]  <= num_out;
                rem_d_reg[s]  <= rem_out;
                den_d_reg[s]  <= den_in;
                mode_d_reg[s] <= mode_in;
                t_d_reg[s]    <= t_in;
                term_d_reg[s] <= term_in;
                qneg_d_reg[s] <= qneg_in;
            end
        end
    end

    logic signed [27:0] q_w;
    logic signed [27:0] sp_w;
    logic signed [27:0] tq_w;
    logic signed [27:0] tm_w;
    logic [QuotW-1:0]   qmag;

    always_comb begin
        qmag = num_d_reg[DivSteps-1];
        q_w  = qneg_d_reg[DivSteps-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        tq_w = 28'(t_d_reg[DivSteps-1]);
        tm_w = 28'(term_d_reg[DivSteps-1]);
        if (q_w > 28'sd1) begin
            sp_w = tq_w + tm_w;
        end else if (q_w < -28'sd1) begin
            sp_w = tq_w - tm_w;
        end else begin
            sp_w = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            case (mode_d_reg[DivSteps-1])
                MODE_ROT: begin
                    sr_reg.speed  <= sat16(tm_w);
                    sr_reg.radius <= 16'd1;
                end
                MODE_TRANS: begin
                    sr_reg.speed  <= tq_w[15:0];
                    sr_reg.radius <= 16'd0;
                end
                default: begin
                    sr_reg.speed  <= sat16(sp_w);
                    sr_reg.radius <= sat16(q_w);
                end
            endcase
        end
    end

    assign out_valid = v_reg[4];
    assign out_sr    = sr_reg;

endmodule

// ===== design/ddsr_frame.sv =====
// Frame serializer: header, speed, radius, checksum, one byte per cycle while m_ready is high.
module ddsr_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ddsr_pkg::sr_t         in_sr,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ddsr_pkg::out_item_t   m_item
);
    import ddsr_pkg::*;

    logic            busy_reg;
    logic [IdxW-1:0] idx_reg;
    sr_t             sr_reg;
    logic [7:0]      cks_w;
    logic [7:0]      byte_w;
    logic            done_w;

    assign done_w   = busy_reg && m_ready && (idx_reg == IdxW'(FrameLen - 1));
    assign in_ready = !busy_reg || done_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (in_valid && in_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (done_w) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sr_reg <= in_sr;
        end
    end

    always_comb begin
        cks_w = HeadB2 ^ HeadB3 ^ HeadB4 ^ sr_reg.speed[7:0] ^ sr_reg.speed[15:8]
              ^ sr_reg.radius[7:0] ^ sr_reg.radius[15:8];
        case (idx_reg)
            4'd0:    byte_w = HeadB0;
            4'd1:    byte_w = HeadB1;
            4'd2:    byte_w = HeadB2;
            4'd3:    byte_w = HeadB3;
            4'd4:    byte_w = HeadB4;
            4'd5:    byte_w = sr_reg.speed[7:0];
            4'd6:    byte_w = sr_reg.speed[15:8];
            4'd7:    byte_w = sr_reg.radius[7:0];
            4'd8:    byte_w = sr_reg.radius[15:8];
            default: byte_w = cks_w;
        endcase
    end

    assign m_valid           = busy_reg;
    assign m_item.frame_byte = byte_w;
    assign m_item.last_byte  = (idx_reg == IdxW'(FrameLen - 1));

endmodule
